// ----- sv/msm_pkg.sv -----
// Shared types and constants for the multichannel sliding median filter.
// No dependencies.
package msm_pkg;

  localparam int unsigned CHAN_W      = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    chan_t   channel;
    sample_t sample;
  } item_t;

endpackage

// ----- sv/msm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/msm_median.sv -----
// Median of one window by rank counting; floor average of the middle pair.
// Depends on msm_pkg.
module msm_median #(
  parameter int unsigned WINDOW = 5
) (
  input  logic [WINDOW*msm_pkg::SAMPLE_W-1:0] slots_i,
  output msm_pkg::sample_t                    median_o
);

  localparam int unsigned RANK_W  = $clog2(WINDOW) + 1;
  localparam int unsigned LO_RANK = (WINDOW - 1) / 2;
  localparam int unsigned HI_RANK = WINDOW / 2;

  msm_pkg::sample_t           s [WINDOW];
  logic [RANK_W-1:0]          rank [WINDOW];
  msm_pkg::sample_t           lo_val;
  msm_pkg::sample_t           hi_val;
  logic [msm_pkg::SAMPLE_W:0] sum;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      s[i] = slots_i[i*msm_pkg::SAMPLE_W +: msm_pkg::SAMPLE_W];
    end
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((s[j] < s[i]) || ((s[j] == s[i]) && (j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RANK_W'(LO_RANK)) begin
        lo_val = lo_val | s[i];
      end
      if (rank[i] == RANK_W'(HI_RANK)) begin
        hi_val = hi_val | s[i];
      end
    end
    sum      = {1'b0, lo_val} + {1'b0, hi_val};
    median_o = sum[msm_pkg::SAMPLE_W:1];
  end

endmodule

// ----- sv/multichannel_sliding_median.sv -----
// Top level of the multichannel sliding median filter: window RAM, forwarding,
// median and output register. Depends on msm_pkg, msm_ram and msm_median.
//
// channel | valid     | ready     | data                  | transfer when
// in      | in_tvalid | in_tready | in_tdata  (24 bits)   | in_tvalid & in_tready
// out     | out_tvalid| out_tready| out_tdata (24 bits)   | out_tvalid & out_tready
// cfg     | cfg_valid | cfg_ready | cfg_data  (1 bit)     | cfg_valid & cfg_ready
//
// One item per cycle sustained while out_tready stays high; out_tvalid rises once the
// input transfer has passed the registered read port of the window RAM and then the
// output register.
// Reset clears all per-channel valid bits together; no clearing pass.
// A stalled output holds the median stage; input stalls only when both are full and out_tready is low.
module multichannel_sliding_median #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned WINDOW   = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [msm_pkg::IN_TDATA_W-1:0]     in_tdata,   // [3:0] channel, [19:4] sample_value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [msm_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [3:0] out_channel, [19:4] filtered_value
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data    // [0] filter_enable
);

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ROW_W = WINDOW * msm_pkg::SAMPLE_W;
  localparam int unsigned SW    = msm_pkg::SAMPLE_W;

  msm_pkg::item_t   in_item;
  logic             in_fire;
  logic             in_hit;
  logic [CH_W-1:0]  in_addr;

  logic             s1_valid_r, s1_valid_nxt;
  msm_pkg::item_t   s1_item_r;
  logic             s1_hit;
  logic [CH_W-1:0]  s1_addr;
  logic             s1_adv;

  logic             byp_r;
  logic [ROW_W-1:0] byp_row_r;

  logic [CHANNELS-1:0] vld_r;
  logic             filter_en_r;

  logic             ram_we;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] old_row;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] new_row;
  msm_pkg::sample_t median;
  msm_pkg::sample_t result;

  logic             out_valid_r;
  logic [msm_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  assign in_item.channel = in_tdata[msm_pkg::CHAN_W-1:0];
  assign in_item.sample  = in_tdata[msm_pkg::CHAN_W +: SW];
  assign in_fire         = in_tvalid && in_tready;
  assign in_hit          = ({3'b000, in_item.channel} < 7'(CHANNELS));
  assign in_addr         = CH_W'(in_item.channel);

  assign s1_hit  = ({3'b000, s1_item_r.channel} < 7'(CHANNELS));
  assign s1_addr = CH_W'(s1_item_r.channel);
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);
  assign ram_we       = s1_adv && s1_hit;
  assign cfg_ready    = 1'b1;

  msm_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr),
    .wdata(new_row),
    .re   (in_fire),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (byp_r) begin
      old_row = byp_row_r;
    end else if (s1_hit && vld_r[s1_addr]) begin
      old_row = ram_rdata;
    end else begin
      old_row = '0;
    end
    cur_row = old_row;
    cur_row[SW-1:0] = s1_item_r.sample;
    new_row = cur_row;
    if (filter_en_r) begin
      for (int k = 1; k < WINDOW; k++) begin
        new_row[k*SW +: SW] = cur_row[(k-1)*SW +: SW];
      end
    end
  end

  msm_median #(
    .WINDOW(WINDOW)
  ) u_median (
    .slots_i (cur_row),
    .median_o(median)
  );

  assign result = (s1_hit && filter_en_r) ? median : s1_item_r.sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      filter_en_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        filter_en_r <= cfg_data;
      end
      if (ram_we) begin
        vld_r[s1_addr] <= 1'b1;
      end
      if (in_fire) begin
        byp_r <= ram_we && in_hit && (in_addr == s1_addr);
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
      byp_row_r <= new_row;
    end
    if (s1_adv) begin
      out_tdata_r <= {4'b0000, result, s1_item_r.channel};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  a_we_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (s1_valid_r && s1_adv && s1_hit))
    else $error("window write without a stage advance");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !filter_en_r) |=> (out_tdata[19:4] == $past(s1_item_r.sample)))
    else $error("disabled filter did not pass the sample");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with an empty median stage");

  a_bypass_same_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ram_we && in_hit && (in_addr == s1_addr)) |=> byp_r)
    else $error("same-channel forwarding missed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0 && !out_valid_r && !s1_valid_r))
    else $error("state not cleared after reset");

endmodule
